@@ hw/rtl/slcan_pkg.sv @@
`timescale 1ns / 1ps

package slcan_pkg;

	localparam int unsigned IdBits    = 32;
	localparam int unsigned DataBits  = 64;
	localparam int unsigned StampBits = 16;

	localparam logic [6:0] ChZero  = 7'h30;
	localparam logic [6:0] ChUpA   = 7'h41;
	localparam logic [6:0] ChCr    = 7'h0D;
	localparam logic [6:0] ChStdD  = 7'h74;
	localparam logic [6:0] ChStdR  = 7'h72;
	localparam logic [6:0] ChExtD  = 7'h54;
	localparam logic [6:0] ChExtR  = 7'h52;

	localparam logic [3:0] MaxBytes = 4'd8;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = ChZero + {3'b000, nib};
		end else begin
			c = ChUpA + {3'b000, nib} - 7'd10;
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/slcan_frame_if.sv @@
`timescale 1ns / 1ps

interface slcan_frame_if;
	logic        valid;
	logic        ready;
	logic        is_extended;
	logic        is_remote;
	logic [28:0] frame_id;
	logic [3:0]  data_length;
	logic [63:0] data_bytes;
	logic [15:0] timestamp_ms;

	modport source (output valid, is_extended, is_remote, frame_id, data_length,
		data_bytes, timestamp_ms, input ready);
	modport sink (input valid, is_extended, is_remote, frame_id, data_length,
		data_bytes, timestamp_ms, output ready);
endinterface

@@ hw/rtl/slcan_char_if.sv @@
`timescale 1ns / 1ps

interface slcan_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;
	logic [4:0] line_length;
	logic       last_char;

	modport source (output valid, ascii_char, line_length, last_char, input ready);
	modport sink (input valid, ascii_char, line_length, last_char, output ready);
endinterface

@@ hw/rtl/slcan_cfg_if.sv @@
`timescale 1ns / 1ps

interface slcan_cfg_if;
	logic valid;
	logic ready;
	logic timestamp_enable;

	modport source (output valid, timestamp_enable, input ready);
	modport sink (input valid, timestamp_enable, output ready);
endinterface

@@ hw/rtl/slcan_nib_shift.sv @@
`timescale 1ns / 1ps

module slcan_nib_shift #(
	parameter int unsigned W = slcan_pkg::IdBits
) (
	input  logic         clk,
	input  logic         load,
	input  logic [W-1:0] load_value,
	input  logic         shift,
	output logic [3:0]   nib
);

	logic [W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_value;
		end else if (shift) begin
			val_q <= {val_q[W-5:0], 4'b0000};
		end
	end

	assign nib = val_q[W-1 -: 4];

endmodule

@@ hw/rtl/can_frame_to_slcan_ascii.sv @@
`timescale 1ns / 1ps
// An accepted frame enters ST_TYPE, whose character is registered once the output register is free.
// Throughput: one character per cycle while line.ready holds, for lines of 6 to 31 characters;
// one hex digit per cycle leaves the nibble shift registers while the output does not stall.
// A new frame is accepted while the closing carriage return waits on the output.
// Reset clears the sequencer, timestamp_enable and output registers but line_length; shift regs are not reset.

module can_frame_to_slcan_ascii (
	input  logic clk,
	input  logic arst_n,
	slcan_cfg_if.sink     cfg,
	slcan_frame_if.sink   frame,
	slcan_char_if.source  line
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_ID,
		ST_LEN,
		ST_DATA,
		ST_TS,
		ST_CR
	} state_t;

	state_t     state_q;
	logic       ts_en_q;
	logic       ext_q;
	logic       rtr_q;
	logic       ts_q;
	logic [3:0] dlc_q;
	logic [3:0] cnt_q;
	logic [4:0] len_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic                            accept;
	logic                            adv;
	logic [3:0]                      id_nib;
	logic [3:0]                      data_nib;
	logic [3:0]                      ts_nib;
	logic [slcan_pkg::IdBits-1:0]    id_load;
	logic [slcan_pkg::DataBits-1:0]  data_load;
	logic [3:0]                      nbytes;
	logic [4:0]                      len_calc;
	logic [4:0]                      data_digits;

	assign cfg.ready   = 1'b1;
	assign frame.ready = (state_q == ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign adv         = (state_q != ST_IDLE) && (!valid_q || line.ready);

	always_comb begin
		id_load = frame.is_extended ? {3'b000, frame.frame_id}
			: {frame.frame_id[11:0], 20'b0};
		for (int k = 0; k < 8; k++) begin
			data_load[63 - 8*k -: 8] = frame.data_bytes[8*k +: 8];
		end
		nbytes   = (frame.data_length > slcan_pkg::MaxBytes) ? slcan_pkg::MaxBytes
			: frame.data_length;
		len_calc = 5'd3 + (frame.is_extended ? 5'd8 : 5'd3)
			+ (frame.is_remote ? 5'd0 : {nbytes, 1'b0})
			+ (ts_en_q ? 5'd4 : 5'd0);
	end

	assign data_digits = {((dlc_q > slcan_pkg::MaxBytes) ? slcan_pkg::MaxBytes
		: dlc_q), 1'b0};

	slcan_nib_shift #(.W(slcan_pkg::IdBits)) u_id (
		.clk        (clk),
		.load       (accept),
		.load_value (id_load),
		.shift      (adv && state_q == ST_ID),
		.nib        (id_nib)
	);

	slcan_nib_shift #(.W(slcan_pkg::DataBits)) u_data (
		.clk        (clk),
		.load       (accept),
		.load_value (data_load),
		.shift      (adv && state_q == ST_DATA),
		.nib        (data_nib)
	);

	slcan_nib_shift #(.W(slcan_pkg::StampBits)) u_ts (
		.clk        (clk),
		.load       (accept),
		.load_value (frame.timestamp_ms),
		.shift      (adv && state_q == ST_TS),
		.nib        (ts_nib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_en_q <= 1'b0;
		end else if (cfg.valid) begin
			ts_en_q <= cfg.timestamp_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cnt_q   <= '0;
			ext_q   <= 1'b0;
			rtr_q   <= 1'b0;
			dlc_q   <= '0;
			ts_q    <= 1'b0;
			len_q   <= '0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			if (line.ready && !adv) begin
				valid_q <= 1'b0;
			end
			if (accept) begin
				ext_q   <= frame.is_extended;
				rtr_q   <= frame.is_remote;
				dlc_q   <= frame.data_length;
				ts_q    <= ts_en_q;
				len_q   <= len_calc;
				state_q <= ST_TYPE;
			end
			if (adv) begin
				valid_q <= 1'b1;
				last_q  <= (state_q == ST_CR);
				unique case (state_q)
					ST_TYPE: begin
						char_q  <= ext_q ? (rtr_q ? slcan_pkg::ChExtR : slcan_pkg::ChExtD)
							: (rtr_q ? slcan_pkg::ChStdR : slcan_pkg::ChStdD);
						cnt_q   <= ext_q ? 4'd7 : 4'd2;
						state_q <= ST_ID;
					end
					ST_ID: begin
						char_q <= slcan_pkg::hex_char(id_nib);
						cnt_q  <= cnt_q - 4'd1;
						if (cnt_q == 4'd0) begin
							state_q <= ST_LEN;
						end
					end
					ST_LEN: begin
						char_q <= rtr_q ? slcan_pkg::ChZero : slcan_pkg::hex_char(dlc_q);
						priority if (!rtr_q && data_digits != 5'd0) begin
							cnt_q   <= 4'(data_digits - 5'd1);
							state_q <= ST_DATA;
						end else if (ts_q) begin
							cnt_q   <= 4'd3;
							state_q <= ST_TS;
						end else begin
							state_q <= ST_CR;
						end
					end
					ST_DATA: begin
						char_q <= slcan_pkg::hex_char(data_nib);
						if (cnt_q == 4'd0) begin
							if (ts_q) begin
								cnt_q   <= 4'd3;
								state_q <= ST_TS;
							end else begin
								state_q <= ST_CR;
							end
						end else begin
							cnt_q <= cnt_q - 4'd1;
						end
					end
					ST_TS: begin
						char_q <= slcan_pkg::hex_char(ts_nib);
						cnt_q  <= cnt_q - 4'd1;
						if (cnt_q == 4'd0) begin
							state_q <= ST_CR;
						end
					end
					ST_CR: begin
						char_q  <= slcan_pkg::ChCr;
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && state_q == ST_TYPE) begin
			line.line_length <= len_q;
		end
	end

	assign line.valid      = valid_q;
	assign line.ascii_char = char_q;
	assign line.last_char  = last_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic        is_extended;
		logic        is_remote;
		logic [28:0] frame_id;
		logic [3:0]  data_length;
		logic [63:0] data_bytes;
		logic [15:0] timestamp_ms;
	} frame_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic [4:0] line_length;
		logic       last_char;
	} char_t;

	typedef struct {
		bit     stamp;
		frame_t f;
		string  text;
	} row_t;

	logic clk;
	logic arst_n;

	slcan_cfg_if   cfg_ch ();
	slcan_frame_if frame_ch ();
	slcan_char_if  line_ch ();

	can_frame_to_slcan_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.frame  (frame_ch),
		.line   (line_ch)
	);

	char_t expected_chars[$];
	row_t  frame_rows[$];
	bit    stamp_on;
	int    gap_pct;
	int    stall_pct;
	int    errors;
	int    frames_sent;
	int    chars_checked;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	function automatic logic [6:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return slcan_pkg::ChZero + 7'(n);
		end
		return slcan_pkg::ChUpA + 7'(n - 4'd10);
	endfunction

	function automatic void predict_line(input frame_t f);
		logic [6:0]  chars[$];
		logic [31:0] id32;
		logic [7:0]  b;
		int          nbytes;
		id32 = {3'b000, f.frame_id};
		if (f.is_extended) begin
			chars.push_back(f.is_remote ? slcan_pkg::ChExtR : slcan_pkg::ChExtD);
			for (int k = 7; k >= 0; k--) begin
				chars.push_back(nibble_char(id32[4*k +: 4]));
			end
		end else begin
			chars.push_back(f.is_remote ? slcan_pkg::ChStdR : slcan_pkg::ChStdD);
			for (int k = 2; k >= 0; k--) begin
				chars.push_back(nibble_char(id32[4*k +: 4]));
			end
		end
		if (f.is_remote) begin
			chars.push_back(slcan_pkg::ChZero);
		end else begin
			chars.push_back(nibble_char(f.data_length));
			nbytes = (f.data_length > 4'd8) ? 8 : int'(f.data_length);
			for (int k = 0; k < nbytes; k++) begin
				b = f.data_bytes[8*k +: 8];
				chars.push_back(nibble_char(b[7:4]));
				chars.push_back(nibble_char(b[3:0]));
			end
		end
		if (stamp_on) begin
			for (int k = 3; k >= 0; k--) begin
				chars.push_back(nibble_char(f.timestamp_ms[4*k +: 4]));
			end
		end
		chars.push_back(slcan_pkg::ChCr);
		foreach (chars[i]) begin
			expected_chars.push_back('{chars[i], 5'(chars.size()), i == chars.size() - 1});
		end
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		f.is_extended = 1'($urandom_range(1));
		f.is_remote   = ($urandom_range(3) == 0);
		case ($urandom_range(5))
			0: begin
				f.frame_id = '0;
			end
			1: begin
				f.frame_id = '1;
			end
			default: begin
				f.frame_id = 29'($urandom);
			end
		endcase
		if ($urandom_range(4) == 0) begin
			f.data_length = 4'($urandom_range(15));
		end else begin
			f.data_length = 4'($urandom_range(8));
		end
		case ($urandom_range(7))
			0: begin
				f.data_bytes = '0;
			end
			1: begin
				f.data_bytes = '1;
			end
			default: begin
				f.data_bytes = {$urandom, $urandom};
			end
		endcase
		f.timestamp_ms = 16'($urandom);
		return f;
	endfunction

	task automatic add_row(input bit stamp, input bit ext, input bit rtr, input logic [28:0] id,
			input logic [3:0] dlc, input logic [63:0] data, input logic [15:0] ts,
			input string text);
		row_t r;
		r.stamp = stamp;
		r.f     = '{ext, rtr, id, dlc, data, ts};
		r.text  = text;
		frame_rows.push_back(r);
	endtask

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_frame(input frame_t f, input string text);
		while ($urandom_range(99) < gap_pct) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.is_extended  <= f.is_extended;
		frame_ch.is_remote    <= f.is_remote;
		frame_ch.frame_id     <= f.frame_id;
		frame_ch.data_length  <= f.data_length;
		frame_ch.data_bytes   <= f.data_bytes;
		frame_ch.timestamp_ms <= f.timestamp_ms;
		@(posedge clk);
		while (!frame_ch.ready) begin
			@(posedge clk);
		end
		if (text.len() == 0) begin
			predict_line(f);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				expected_chars.push_back('{7'(text[i]), 5'(text.len() + 1), 1'b0});
			end
			expected_chars.push_back('{slcan_pkg::ChCr, 5'(text.len() + 1), 1'b1});
		end
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic settle_and_config(input bit value);
		frame_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) begin
			@(negedge clk);
		end
		cfg_ch.valid            <= 1'b1;
		cfg_ch.timestamp_enable <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		stamp_on = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		line_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		char_t got;
		char_t want;
		if (arst_n && line_ch.valid && line_ch.ready) begin
			got = '{line_ch.ascii_char, line_ch.line_length, line_ch.last_char};
			chars_checked++;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("character 0x%02h with no line pending", got.ascii_char));
			end else begin
				want = expected_chars.pop_front();
				if (got.ascii_char !== want.ascii_char) begin
					report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h",
						got.ascii_char, want.ascii_char));
				end
				if (got.line_length !== want.line_length) begin
					report_mismatch($sformatf("line_length %0d, want %0d",
						got.line_length, want.line_length));
				end
				if (got.last_char !== want.last_char) begin
					report_mismatch($sformatf("last_char %0b, want %0b",
						got.last_char, want.last_char));
				end
			end
		end
	end

	initial begin
		arst_n                  = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.timestamp_enable = 1'b0;
		frame_ch.valid          = 1'b0;
		frame_ch.is_extended    = 1'b0;
		frame_ch.is_remote      = 1'b0;
		frame_ch.frame_id       = '0;
		frame_ch.data_length    = '0;
		frame_ch.data_bytes     = '0;
		frame_ch.timestamp_ms   = '0;
		line_ch.ready           = 1'b0;
		stamp_on                = 1'b0;
		gap_pct                 = 0;
		stall_pct               = 0;
		errors                  = 0;
		frames_sent             = 0;
		chars_checked           = 0;

		add_row(0, 0, 0, 29'h0, 4'd0, 64'h0, 16'h0, "t0000");
		add_row(0, 0, 0, 29'h7FF, 4'd8, 64'h0123456789ABCDEF, 16'h0, "t7FF8EFCDAB8967452301");
		add_row(0, 0, 1, 29'h123, 4'd5, 64'hDEADBEEF, 16'hFFFF, "r1230");
		add_row(0, 1, 0, 29'h1FFFFFFF, 4'd8, '1, 16'h0,
			{"T1FFFFFFF8", "FFFFFFFFFFFFFFFF"});
		add_row(0, 1, 1, 29'h0, 4'd0, 64'h0, 16'h0, "R000000000");
		add_row(0, 0, 0, 29'h1FFFFABC, 4'd0, 64'h0, 16'h0, "tABC0");
		add_row(0, 0, 0, 29'h800, 4'd1, 64'h5A, 16'h0, "t80015A");
		add_row(0, 0, 0, 29'h001, 4'd9, 64'h0011223344556677, 16'h0, "t00197766554433221100");
		add_row(0, 1, 0, 29'h12345678, 4'd15, 64'h0, 16'h0,
			{"T12345678F", "0000000000000000"});
		add_row(0, 1, 1, 29'h0ABCDEF, 4'd15, '1, 16'hFFFF, "");
		add_row(0, 0, 0, 29'h5A5, 4'd4, 64'hFEDCBA9876543210, 16'h8001, "");
		add_row(0, 1, 0, 29'h15555555, 4'd3, 64'h00A5C3, 16'h0, "");
		add_row(1, 0, 0, 29'h0, 4'd0, 64'h0, 16'hFFFF, "t0000FFFF");
		add_row(1, 1, 0, 29'h1FFFFFFF, 4'd8, '1, 16'hFFFF,
			{"T1FFFFFFF8", "FFFFFFFFFFFFFFFF", "FFFF"});
		add_row(1, 1, 1, 29'h1ABCDEF0, 4'd2, 64'h0, 16'h1234, "R1ABCDEF001234");
		add_row(1, 0, 1, 29'h7FF, 4'd0, 64'h0, 16'h0, "r7FF00000");
		add_row(1, 0, 0, 29'h3C3, 4'd10, 64'h8899AABBCCDDEEFF, 16'hA5F0, "");
		add_row(1, 1, 0, 29'h0000001, 4'd7, 64'h0102030405060708, 16'h0F0F, "");

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first rows rely on the reset value of the stamp enable
		foreach (frame_rows[i]) begin
			if (frame_rows[i].stamp != stamp_on) begin
				settle_and_config(frame_rows[i].stamp);
			end
			send_frame(frame_rows[i].f, frame_rows[i].text);
		end

		for (int p = 0; p < 8; p++) begin
			case (p / 2)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 79;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 79;
				end
				default: begin
					gap_pct   = 26;
					stall_pct = 26;
				end
			endcase
			settle_and_config(p[0]);
			repeat (58) begin
				send_frame(random_frame(), "");
			end
		end

		frame_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(posedge clk);
		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
		end

		$display("%0d frames encoded, %0d characters checked, %0d mismatches", frames_sent,
			chars_checked, errors);
		$display("covered all frame types, lengths 0 to 15, stamps on and off, four pacing mixes");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout: output stream stopped");
		$display("FAIL");
		$finish;
	end

endmodule
